@@ hdl/lzw_variable_width_encoder_unit_macros.svh @@
// Assertion macros used by the checker file.
`ifndef LZW_VARIABLE_WIDTH_ENCODER_UNIT_MACROS_SVH
`define LZW_VARIABLE_WIDTH_ENCODER_UNIT_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define LZWVE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger.
`define LZWVE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lzwve_pkg.sv @@
package lzwve_pkg;

	// Register map
	localparam int PADDR_W = 3;
	localparam logic REG_START_BITS = 1'b0;
	localparam logic REG_MAX_BITS   = 1'b1;

	localparam logic [4:0] START_BITS_RST = 5'd9;
	localparam logic [4:0] MAX_BITS_RST   = 5'd12;
	localparam logic [4:0] WIDTH_MIN      = 5'd8;
	localparam logic [4:0] WIDTH_MAX      = 5'd24;

	// Hash: multiplicative mix, product bits taken above this shift
	localparam logic [63:0] HASH_MULT  = 64'h9E3779B97F4A7C15;
	localparam int          HASH_SHIFT = 20;

	// Dictionary generation mark
	localparam int EPOCH_BITS = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [23:0] code_value;
		logic [4:0]  code_width;
		logic        last_code;
		logic        config_error;
	} out_item_t;

	typedef struct packed {
		logic [4:0] start_bits;
		logic [4:0] max_bits;
	} cfg_t;

	// Word passed from front to back
	typedef struct packed {
		logic       bad_cfg;
		logic [7:0] data_byte;
		logic       end_of_stream;
	} cmd_t;

endpackage

@@ hdl/lzwve_fifo.sv @@
module lzwve_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	output logic         full,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Store incoming words
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

@@ hdl/lzwve_front.sv @@
module lzwve_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lzwve_pkg::in_item_t item,
	output logic              full,
	input  lzwve_pkg::cfg_t   cfg,
	input  logic              cmd_pop,
	output logic              cmd_valid,
	output lzwve_pkg::cmd_t   cmd
);
	import lzwve_pkg::*;

	cmd_t cmd_in;
	logic cmd_empty;

	// Flag the word when the width settings are unusable
	always_comb begin
		cmd_in.bad_cfg = (cfg.start_bits < WIDTH_MIN) || (cfg.max_bits > WIDTH_MAX) ||
			(cfg.start_bits > cfg.max_bits);
		cmd_in.data_byte     = item.data_byte;
		cmd_in.end_of_stream = item.end_of_stream;
	end

	lzwve_fifo #(.W($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd_in),
		.full    (full),
		.rd_en   (cmd_pop),
		.rd_data (cmd),
		.empty   (cmd_empty)
	);

	assign cmd_valid = !cmd_empty;
endmodule

@@ hdl/lzwve_back.sv @@
module lzwve_back #(
	parameter int DICT_CODE_BITS = 12,
	parameter int HASH_SLOTS     = 8192
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lzwve_pkg::cfg_t      cfg,
	input  logic                 cmd_valid,
	input  lzwve_pkg::cmd_t      cmd,
	output logic                 cmd_pop,
	input  logic                 out_full,
	output logic                 out_push,
	output lzwve_pkg::out_item_t out_word
);
	import lzwve_pkg::*;

	localparam int HB  = $clog2(HASH_SLOTS);
	localparam int DCB = DICT_CODE_BITS;
	localparam int NW  = DCB + 1;
	localparam logic [22:0] MULT_LO = HASH_MULT[22:0];
	localparam logic [21:0] MULT_HI = HASH_MULT[44:23];

	typedef struct packed {
		logic                  valid;
		logic [EPOCH_BITS-1:0] epoch;
		logic [DCB-1:0]        prefix;
		logic [7:0]            data_byte;
		logic [DCB-1:0]        code;
	} entry_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_HASH_A, ST_HASH_B, ST_READ, ST_CHECK, ST_MISS, ST_LAST, ST_ERR
	} state_t;

	state_t                state_q;
	logic [EPOCH_BITS-1:0] epoch_q;
	logic [HB-1:0]         clr_idx_q;
	logic                  have_q;
	logic [DCB-1:0]        prefix_q;
	logic [NW-1:0]         nfc_q;
	logic [4:0]            cw_q;
	cmd_t                  cur_q;
	logic [HB-1:0]         slot_q;
	logic [HB:0]           probe_q;
	logic                  free_ok_q;
	logic [54:0]           plo_q;
	logic [53:0]           phi_q;

	entry_t mem [HASH_SLOTS];
	entry_t rd_q;

	logic [31:0]   key;
	logic [63:0]   hash_sum;
	logic          live;
	logic          match;
	logic          widen;
	logic [4:0]    lim_bits;
	logic          insert;
	logic          we;
	logic [HB-1:0] wa;
	entry_t        wd;

	// Hash key and mix
	assign key      = {24'(prefix_q), cur_q.data_byte};
	assign hash_sum = 64'(plo_q) + (64'(phi_q) << 23);

	// Probe compare
	assign live  = rd_q.valid && (rd_q.epoch == epoch_q);
	assign match = (rd_q.prefix == prefix_q) && (rd_q.data_byte == cur_q.data_byte);

	// Width growth and insert decisions
	assign widen    = (cw_q < WIDTH_MAX) && (25'(nfc_q) == (25'd1 << cw_q)) &&
		(cw_q < cfg.max_bits);
	assign lim_bits = (cfg.max_bits < 5'(DCB)) ? cfg.max_bits : 5'(DCB);
	assign insert   = 25'(nfc_q) < (25'd1 << lim_bits);

	// Drive the pop of the command queue
	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	// Drive result words
	always_comb begin
		out_push = !out_full &&
			((state_q == ST_ERR) || (state_q == ST_MISS) || (state_q == ST_LAST));
		out_word.code_value   = 24'(prefix_q);
		out_word.code_width   = cw_q;
		out_word.last_code    = (state_q == ST_LAST);
		out_word.config_error = 1'b0;
		if (state_q == ST_ERR) begin
			out_word.code_value   = '0;
			out_word.code_width   = '0;
			out_word.config_error = 1'b1;
		end
	end

	// Select the table write
	always_comb begin
		we = 1'b0;
		wa = slot_q;
		wd = '0;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			wa = clr_idx_q;
		end else if ((state_q == ST_MISS) && !out_full && insert && free_ok_q) begin
			we           = 1'b1;
			wd.valid     = 1'b1;
			wd.epoch     = epoch_q;
			wd.prefix    = prefix_q;
			wd.data_byte = cur_q.data_byte;
			wd.code      = nfc_q[DCB-1:0];
		end
	end

	// Dictionary memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (state_q == ST_READ) begin
			rd_q <= mem[slot_q];
		end
	end

	// Hash product stages
	always_ff @(posedge clk) begin
		if (state_q == ST_HASH_A) begin
			plo_q <= key * MULT_LO;
			phi_q <= key * MULT_HI;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			epoch_q   <= '0;
			clr_idx_q <= '0;
			have_q    <= 1'b0;
			prefix_q  <= '0;
			nfc_q     <= NW'(256);
			cw_q      <= START_BITS_RST;
			cur_q     <= '0;
			slot_q    <= '0;
			probe_q   <= '0;
			free_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == HB'(HASH_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cur_q <= cmd;
						if (cmd.bad_cfg) begin
							state_q <= ST_ERR;
						end else if (!have_q) begin
							// open a new stream on this byte
							have_q   <= 1'b1;
							prefix_q <= DCB'(cmd.data_byte);
							cw_q     <= cfg.start_bits;
							nfc_q    <= NW'(256);
							state_q  <= cmd.end_of_stream ? ST_LAST : ST_IDLE;
						end else begin
							probe_q <= '0;
							state_q <= ST_HASH_A;
						end
					end
				end
				ST_HASH_A: begin
					state_q <= ST_HASH_B;
				end
				ST_HASH_B: begin
					slot_q  <= hash_sum[HASH_SHIFT +: HB];
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!live) begin
						free_ok_q <= 1'b1;
						state_q   <= ST_MISS;
					end else if (match) begin
						prefix_q <= rd_q.code;
						state_q  <= cur_q.end_of_stream ? ST_LAST : ST_IDLE;
					end else if (probe_q == (HB+1)'(HASH_SLOTS - 1)) begin
						// table full: the code is used up without a slot
						free_ok_q <= 1'b0;
						state_q   <= ST_MISS;
					end else begin
						slot_q  <= slot_q + 1'b1;
						probe_q <= probe_q + 1'b1;
						state_q <= ST_READ;
					end
				end
				ST_MISS: begin
					if (!out_full) begin
						if (widen) begin
							cw_q <= cw_q + 1'b1;
						end
						if (insert) begin
							nfc_q <= nfc_q + 1'b1;
						end
						prefix_q <= DCB'(cur_q.data_byte);
						state_q  <= cur_q.end_of_stream ? ST_LAST : ST_IDLE;
					end
				end
				ST_LAST: begin
					if (!out_full) begin
						have_q   <= 1'b0;
						prefix_q <= '0;
						nfc_q    <= NW'(256);
						epoch_q  <= epoch_q + 1'b1;
						// sweep the table once the generation mark wraps
						if (epoch_q == '1) begin
							clr_idx_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (!out_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

@@ hdl/lzw_variable_width_encoder_unit.sv @@
// LZW encoder with variable code width. Push one byte per word; codes come out
// with their width on the result queue, at most two per byte (the miss code,
// and the final prefix on the end-of-stream byte). A byte that extends the
// prefix goes through the hash stages, a dictionary read and a check; each
// extra probe of the linear-probed hash table repeats the read and check. The
// first byte of a stream only opens the prefix. A miss or the last code waits
// while the result queue is full. The dictionary has one read port and is
// read one probe at a time. It is cleared by generation marks; after reset, and
// after every 256 streams, a sweep clears all slots and holds off bytes. A bad
// start_bits/max_bits setting gives one word with config_error set.
module lzw_variable_width_encoder_unit #(
	parameter int DICT_CODE_BITS = 12,
	parameter int HASH_SLOTS     = 8192
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [lzwve_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 push,
	input  lzwve_pkg::in_item_t                  item,
	output logic                                 full,
	input  logic                                 pop,
	output lzwve_pkg::out_item_t                 result,
	output logic                                 empty
);
	import lzwve_pkg::*;

	cfg_t      cfg_q;
	logic      cmd_valid;
	logic      cmd_pop;
	cmd_t      cmd;
	logic      out_full;
	logic      out_push;
	out_item_t out_word;

	assign pready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_bits <= START_BITS_RST;
			cfg_q.max_bits   <= MAX_BITS_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_START_BITS: cfg_q.start_bits <= pwdata[4:0];
				REG_MAX_BITS:   cfg_q.max_bits   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	// Return register contents
	always_comb begin
		unique case (paddr[2])
			REG_START_BITS: prdata = 32'(cfg_q.start_bits);
			REG_MAX_BITS:   prdata = 32'(cfg_q.max_bits);
			default:        prdata = '0;
		endcase
	end

	lzwve_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.cfg       (cfg_q),
		.cmd_pop   (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	lzwve_back #(.DICT_CODE_BITS(DICT_CODE_BITS), .HASH_SLOTS(HASH_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_word  (out_word)
	);

	lzwve_fifo #(.W($bits(out_item_t)), .DEPTH(4)) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_word),
		.full    (out_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);
endmodule

@@ hdl/lzwve_checker.sv @@
`include "lzw_variable_width_encoder_unit_macros.svh"

module lzwve_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 pop,
	input logic                 empty,
	input lzwve_pkg::out_item_t result
);
	import lzwve_pkg::*;

	// Error words carry no code
	`LZWVE_ASSERT_NOW(a_err_zero, clk, arst_n, !empty && result.config_error, result.code_value == 24'd0 && result.code_width == 5'd0 && !result.last_code, "error word carries a code")
	// Code words stay within the legal widths
	`LZWVE_ASSERT_NOW(a_width_range, clk, arst_n, !empty && !result.config_error, result.code_width >= WIDTH_MIN && result.code_width <= WIDTH_MAX, "code width out of range")
	// Code fits in its width
	`LZWVE_ASSERT_NOW(a_code_fits, clk, arst_n, !empty && !result.config_error, (32'(result.code_value) >> result.code_width) == 32'd0, "code exceeds its width")
	// Waiting word stays offered
	`LZWVE_ASSERT_NEXT(a_hold_valid, clk, arst_n, !empty && !pop, !empty, "result withdrawn")
	// Waiting word holds its value
	`LZWVE_ASSERT_NEXT(a_hold_data, clk, arst_n, !empty && !pop, $stable(result), "result changed while waiting")
endmodule

bind lzw_variable_width_encoder_unit lzwve_checker u_lzwve_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.pop    (pop),
	.empty  (empty),
	.result (result)
);
